FILE: rtl/drt_pkg.sv
// Shared types, codes and helper functions for the trace reverse-complement block.
// No dependencies; used by dna_trace_reverse_complement and its testbench.
package drt_pkg;

  typedef enum logic [2:0] {
    CMD_WR_PT  = 3'd0,
    CMD_WR_BS  = 3'd1,
    CMD_XFORM  = 3'd2,
    CMD_RD_PT  = 3'd3,
    CMD_RD_BS  = 3'd4,
    CMD_RD_CUT = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_POINT_COUNT = 3'd0,
    REG_BASE_COUNT  = 3'd1,
    REG_SEQ_LEN     = 3'd2,
    REG_LEFT_CUT    = 3'd3,
    REG_RIGHT_CUT   = 3'd4,
    REG_PYRO_MODE   = 3'd5
  } reg_t;

  localparam int PT_W    = 64;
  localparam int BS_W    = 52;
  localparam int POS_W   = 12;
  localparam int CUT_W   = 17;
  localparam int IN_TD_W = 128;
  localparam int OUT_TD_W = 152;

  // Complement one base character.
  function automatic logic [7:0] comp_base(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      "A": r = "T";  "T": r = "A";
      "C": r = "G";  "G": r = "C";
      "a": r = "t";  "t": r = "a";
      "c": r = "g";  "g": r = "c";
      "D": r = "H";  "H": r = "D";
      "B": r = "V";  "V": r = "B";
      "K": r = "N";  "N": r = "K";
      "L": r = "M";  "M": r = "L";
      "R": r = "Y";  "Y": r = "R";
      "5": r = "6";  "6": r = "5";
      "7": r = "7";  "8": r = "8";
      default: r = "-";
    endcase
    return r;
  endfunction

  // Swap channels A/T and C/G of a point word.
  function automatic logic [PT_W-1:0] swap_point(input logic [PT_W-1:0] w);
    return {w[15:0], w[31:16], w[47:32], w[63:48]};
  endfunction

endpackage

FILE: rtl/drt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; instantiated twice by dna_trace_reverse_complement.
module drt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dna_trace_reverse_complement.sv
// Trace reverse-complement block: point and base stores with a transform sequencer.
// Depends on drt_pkg and drt_ram.
//
//  channel | ports                         | word contents
//  --------+-------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata  | command in tuser; index, samples, base rec
//  out     | out_tvalid/out_tready/out_tdata| read point, read base or swapped cutoffs
//  cfg     | cfg_valid/cfg_ready           | cfg_index selects register, cfg_data value
//
// A write goes straight to its store on acceptance; a read first moves to S_RD, which loads
// the output word and out_tvalid registers and keeps the input closed while it lasts.
// A transform mirrors min(point_count,MAX_POINTS) points, then min(base_count,MAX_BASES)
// bases, one pair at a time as each store has a single read and write port, plus a pyro
// pass over base pairs in pyro mode.
// Reset clears config, FSM state and out_tvalid; stores are undefined until written.
// A stalled output word holds; in_tready drops while busy or while the word waits.
module dna_trace_reverse_complement #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_BASES  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // index, trace_a, trace_c, trace_g, trace_t, base, position, prob_a/c/g/t
  input  logic [127:0] in_tdata,
  // command
  input  logic [2:0]   in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // trace_a/c/g/t, base, position, prob_a/c/g/t, new_left_cut, new_right_cut, 2 pad
  output logic [151:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int PAW = $clog2(MAX_POINTS);
  localparam int BAW = $clog2(MAX_BASES);
  localparam int NPW = $clog2(MAX_POINTS + 1);
  localparam int NBW = $clog2(MAX_BASES + 1);
  localparam int CW  = (PAW > BAW) ? PAW : BAW;
  localparam int TW  = ((NPW > 12) ? NPW : 12) + 2;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RD     = 16'h0002,
    S_PT_RLO = 16'h0004,
    S_PT_RHI = 16'h0008,
    S_PT_WLO = 16'h0010,
    S_PT_WHI = 16'h0020,
    S_BS_RLO = 16'h0040,
    S_BS_RHI = 16'h0080,
    S_BS_WLO = 16'h0100,
    S_BS_WHI = 16'h0200,
    S_PY_RA  = 16'h0400,
    S_PY_RB  = 16'h0800,
    S_PY_CMP = 16'h1000,
    S_PY_RJ2 = 16'h2000,
    S_PY_SW  = 16'h4000,
    S_PY_WJ2 = 16'h8000
  } state_t;

  state_t st_r, st_nxt;

  // configuration
  logic [12:0] point_count_r;
  logic [10:0] base_count_r;
  logic [15:0] seq_len_r, left_cut_r, right_cut_r;
  logic        pyro_r;

  // sequencer
  logic [NPW-1:0] np_r, np_nxt;
  logic [NBW-1:0] nb_r, nb_nxt;
  logic [CW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [drt_pkg::PT_W-1:0] lo_pt_r, lo_pt_nxt;
  logic [drt_pkg::BS_W-1:0] lo_bs_r, lo_bs_nxt;
  logic [drt_pkg::POS_W-1:0] j1_r, j1_nxt, j2_r, j2_nxt;
  logic p1_zero_r, p1_zero_nxt;
  logic [drt_pkg::CUT_W-1:0] lcut_res_r, lcut_res_nxt, rcut_res_r, rcut_res_nxt;

  // read request
  logic [2:0] rd_cmd_r, rd_cmd_nxt;
  logic       rd_ok_r, rd_ok_nxt;

  // output
  logic [151:0] out_data_r, out_data_nxt;
  logic         out_valid_r, out_valid_nxt;

  // memories
  logic pt_we, pt_re, bs_we, bs_re;
  logic [PAW-1:0] pt_wa, pt_ra;
  logic [BAW-1:0] bs_wa, bs_ra;
  logic [drt_pkg::PT_W-1:0] pt_wd, pt_rd;
  logic [drt_pkg::BS_W-1:0] bs_wd, bs_rd;

  // input fields
  logic        in_acc;
  logic [11:0] f_index;
  logic        pt_in_range, bs_in_range;

  assign in_acc      = in_tvalid && in_tready;
  assign f_index     = in_tdata[11:0];
  assign pt_in_range = 32'(f_index) < MAX_POINTS;
  assign bs_in_range = 32'(f_index) < MAX_BASES;
  assign in_tready   = (st_r == S_IDLE) && (!out_valid_r || out_tready);
  assign cfg_ready   = 1'b1;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

  drt_ram #(.WIDTH(drt_pkg::PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(pt_wd),
    .re(pt_re), .raddr(pt_ra), .rdata(pt_rd)
  );

  drt_ram #(.WIDTH(drt_pkg::BS_W), .DEPTH(MAX_BASES)) u_bs_ram (
    .clk(clk), .we(bs_we), .waddr(bs_wa), .wdata(bs_wd),
    .re(bs_re), .raddr(bs_ra), .rdata(bs_rd)
  );

  // Complement a base record: mirror position, swap probabilities.
  function automatic logic [drt_pkg::BS_W-1:0] xf_base(input logic [drt_pkg::BS_W-1:0] w,
                                                       input logic [NPW-1:0] np);
    logic signed [TW-1:0] tp;
    logic [11:0] pos;
    tp = $signed(TW'(np)) - $signed(TW'(w[19:8])) - $signed(TW'(1));
    if (tp <= 0) begin
      pos = '0;
    end else if (tp > $signed(TW'(4095))) begin
      pos = 12'hFFF;
    end else begin
      pos = tp[11:0];
    end
    return {w[27:20], w[35:28], w[43:36], w[51:44], pos, drt_pkg::comp_base(w[7:0])};
  endfunction

  // Mirror one cutoff against the sequence length, saturating at zero; zero stays zero.
  function automatic logic [16:0] mirror_cut(input logic [15:0] other,
                                             input logic [15:0] len);
    logic signed [17:0] v;
    v = $signed({2'b00, len}) - $signed({2'b00, other}) + 18'sd1;
    if (other == 16'd0 || v <= 0) begin
      return '0;
    end
    return v[16:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      base_count_r  <= '0;
      seq_len_r     <= '0;
      left_cut_r    <= '0;
      right_cut_r   <= '0;
      pyro_r        <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        drt_pkg::REG_POINT_COUNT: point_count_r <= cfg_data[12:0];
        drt_pkg::REG_BASE_COUNT:  base_count_r  <= cfg_data[10:0];
        drt_pkg::REG_SEQ_LEN:     seq_len_r     <= cfg_data;
        drt_pkg::REG_LEFT_CUT:    left_cut_r    <= cfg_data;
        drt_pkg::REG_RIGHT_CUT:   right_cut_r   <= cfg_data;
        drt_pkg::REG_PYRO_MODE:   pyro_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    np_nxt        = np_r;
    nb_nxt        = nb_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lo_pt_nxt     = lo_pt_r;
    lo_bs_nxt     = lo_bs_r;
    j1_nxt        = j1_r;
    j2_nxt        = j2_r;
    p1_zero_nxt   = p1_zero_r;
    lcut_res_nxt  = lcut_res_r;
    rcut_res_nxt  = rcut_res_r;
    rd_cmd_nxt    = rd_cmd_r;
    rd_ok_nxt     = rd_ok_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    pt_we = 1'b0;  pt_re = 1'b0;  bs_we = 1'b0;  bs_re = 1'b0;
    pt_wa = PAW'(lo_r);  pt_ra = PAW'(lo_r);  pt_wd = '0;
    bs_wa = BAW'(lo_r);  bs_ra = BAW'(lo_r);  bs_wd = '0;

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            drt_pkg::CMD_WR_PT: begin
              pt_we = pt_in_range;
              pt_wa = PAW'(f_index);
              pt_wd = in_tdata[75:12];
            end
            drt_pkg::CMD_WR_BS: begin
              bs_we = bs_in_range;
              bs_wa = BAW'(f_index);
              bs_wd = in_tdata[127:76];
            end
            drt_pkg::CMD_XFORM: begin
              np_nxt = (32'(point_count_r) >= MAX_POINTS) ? NPW'(MAX_POINTS)
                                                         : NPW'(point_count_r);
              nb_nxt = (32'(base_count_r) >= MAX_BASES) ? NBW'(MAX_BASES)
                                                       : NBW'(base_count_r);
              lcut_res_nxt = mirror_cut(right_cut_r, seq_len_r);
              rcut_res_nxt = mirror_cut(left_cut_r, seq_len_r);
              lo_nxt = '0;
              // start with the point pass; skip straight to bases if empty
              if (np_nxt != '0) begin
                hi_nxt = CW'(np_nxt - NPW'(1));
                st_nxt = S_PT_RLO;
              end else if (nb_nxt != '0) begin
                hi_nxt = CW'(nb_nxt - NBW'(1));
                st_nxt = S_BS_RLO;
              end
            end
            drt_pkg::CMD_RD_PT, drt_pkg::CMD_RD_BS, drt_pkg::CMD_RD_CUT: begin
              pt_re = (in_tuser == drt_pkg::CMD_RD_PT) && pt_in_range;
              pt_ra = PAW'(f_index);
              bs_re = (in_tuser == drt_pkg::CMD_RD_BS) && bs_in_range;
              bs_ra = BAW'(f_index);
              rd_cmd_nxt = in_tuser;
              rd_ok_nxt  = (in_tuser == drt_pkg::CMD_RD_PT) ? pt_in_range
                         : (in_tuser == drt_pkg::CMD_RD_BS) ? bs_in_range : 1'b1;
              st_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        // load the output word; unused fields stay zero
        out_data_nxt = '0;
        if (rd_ok_r) begin
          case (rd_cmd_r)
            drt_pkg::CMD_RD_PT:  out_data_nxt[63:0]    = pt_rd;
            drt_pkg::CMD_RD_BS:  out_data_nxt[115:64]  = bs_rd;
            drt_pkg::CMD_RD_CUT: out_data_nxt[149:116] = {rcut_res_r, lcut_res_r};
            default: ;
          endcase
        end
        out_valid_nxt = 1'b1;
        st_nxt = S_IDLE;
      end

      // point pass: swap channels and mirror order, one pair at a time
      S_PT_RLO: begin
        pt_re  = 1'b1;
        pt_ra  = PAW'(lo_r);
        st_nxt = S_PT_RHI;
      end
      S_PT_RHI: begin
        pt_re     = 1'b1;
        pt_ra     = PAW'(hi_r);
        lo_pt_nxt = pt_rd;
        st_nxt    = S_PT_WLO;
      end
      S_PT_WLO: begin
        pt_we  = 1'b1;
        pt_wa  = PAW'(lo_r);
        pt_wd  = drt_pkg::swap_point(pt_rd);
        st_nxt = S_PT_WHI;
      end
      S_PT_WHI: begin
        pt_we = 1'b1;
        pt_wa = PAW'(hi_r);
        pt_wd = drt_pkg::swap_point(lo_pt_r);
        if (({1'b0, lo_r} + (CW+1)'(1)) < {1'b0, hi_r}) begin
          lo_nxt = lo_r + CW'(1);
          hi_nxt = hi_r - CW'(1);
          st_nxt = S_PT_RLO;
        end else if (nb_r != '0) begin
          lo_nxt = '0;
          hi_nxt = CW'(nb_r - NBW'(1));
          st_nxt = S_BS_RLO;
        end else begin
          st_nxt = S_IDLE;
        end
      end

      // base pass: complement records and mirror order
      S_BS_RLO: begin
        bs_re  = 1'b1;
        bs_ra  = BAW'(lo_r);
        st_nxt = S_BS_RHI;
      end
      S_BS_RHI: begin
        bs_re     = 1'b1;
        bs_ra     = BAW'(hi_r);
        lo_bs_nxt = bs_rd;
        st_nxt    = S_BS_WLO;
      end
      S_BS_WLO: begin
        bs_we  = 1'b1;
        bs_wa  = BAW'(lo_r);
        bs_wd  = xf_base(bs_rd, np_r);
        st_nxt = S_BS_WHI;
      end
      S_BS_WHI: begin
        bs_we = 1'b1;
        bs_wa = BAW'(hi_r);
        bs_wd = xf_base(lo_bs_r, np_r);
        if (({1'b0, lo_r} + (CW+1)'(1)) < {1'b0, hi_r}) begin
          lo_nxt = lo_r + CW'(1);
          hi_nxt = hi_r - CW'(1);
          st_nxt = S_BS_RLO;
        end else if (pyro_r && (nb_r >= NBW'(2))) begin
          hi_nxt = CW'(nb_r - NBW'(1));
          st_nxt = S_PY_RA;
        end else begin
          st_nxt = S_IDLE;
        end
      end

      // pyro pass: walk base pairs from the end; hi_r holds the later base
      S_PY_RA: begin
        bs_re  = 1'b1;
        bs_ra  = BAW'(hi_r - CW'(1));
        st_nxt = S_PY_RB;
      end
      S_PY_RB: begin
        bs_re     = 1'b1;
        bs_ra     = BAW'(hi_r);
        lo_bs_nxt = bs_rd;
        st_nxt    = S_PY_CMP;
      end
      S_PY_CMP: begin
        j1_nxt = lo_bs_r[19:8];
        j2_nxt = bs_rd[19:8];
        if (lo_bs_r[7:0] == bs_rd[7:0] && 32'(lo_bs_r[19:8]) < MAX_POINTS &&
            32'(bs_rd[19:8]) < MAX_POINTS) begin
          pt_re  = 1'b1;
          pt_ra  = PAW'(lo_bs_r[19:8]);
          st_nxt = S_PY_RJ2;
        end else if (hi_r == CW'(1)) begin
          st_nxt = S_IDLE;
        end else begin
          hi_nxt = hi_r - CW'(1);
          st_nxt = S_PY_RA;
        end
      end
      S_PY_RJ2: begin
        pt_re       = 1'b1;
        pt_ra       = PAW'(j2_r);
        p1_zero_nxt = (pt_rd == '0);
        st_nxt      = S_PY_SW;
      end
      S_PY_SW: begin
        pt_wa = PAW'(j1_r);
        pt_wd = pt_rd;
        if (p1_zero_r) begin
          pt_we  = 1'b1;
          st_nxt = S_PY_WJ2;
        end else if (hi_r == CW'(1)) begin
          st_nxt = S_IDLE;
        end else begin
          hi_nxt = hi_r - CW'(1);
          st_nxt = S_PY_RA;
        end
      end
      S_PY_WJ2: begin
        // the empty point moves to j2
        pt_we = 1'b1;
        pt_wa = PAW'(j2_r);
        pt_wd = '0;
        if (hi_r == CW'(1)) begin
          st_nxt = S_IDLE;
        end else begin
          hi_nxt = hi_r - CW'(1);
          st_nxt = S_PY_RA;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      lcut_res_r  <= '0;
      rcut_res_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      lcut_res_r  <= lcut_res_nxt;
      rcut_res_r  <= rcut_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    np_r       <= np_nxt;
    nb_r       <= nb_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lo_pt_r    <= lo_pt_nxt;
    lo_bs_r    <= lo_bs_nxt;
    j1_r       <= j1_nxt;
    j2_r       <= j2_nxt;
    p1_zero_r  <= p1_zero_nxt;
    rd_cmd_r   <= rd_cmd_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  // a transform with work to do keeps the input side closed on the following cycle
  a_xform_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == drt_pkg::CMD_XFORM &&
    (point_count_r != '0 || base_count_r != '0) |=> !in_tready)
    else $error("input accepted right after transform");

  // a new output word only comes from the read state
  a_out_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_RD))
    else $error("output word without read");

  // the sequencer never writes both stores in one cycle
  a_one_store_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(pt_we && bs_we))
    else $error("both stores written at once");

endmodule

FILE: bench/dna_trace_reverse_complement_tb.sv
// Self-checking testbench for dna_trace_reverse_complement: stream loads, reads and transforms
// checked against an in-bench store model. Depends on drt_pkg and the block's RTL only.
module dna_trace_reverse_complement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 4096;
  localparam int NBAS = 1024;
  // slots loaded up front; random point reads and all transforms stay inside them
  localparam int FILL_PTS = 64;
  localparam int FILL_BS  = 32;
  // command codes the block must ignore
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  dna_trace_reverse_complement u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block: stores, registers and stored cutoff results.
  logic [63:0] trace_mem [NPTS];
  logic [51:0] call_mem [NBAS];
  logic [12:0] n_points;
  logic [10:0] n_bases;
  logic [15:0] seq_len, cut_left, cut_right;
  logic        pyro_on;
  logic [16:0] left_cut_res, right_cut_res;

  // Expected read words, oldest first, in the out_tdata layout (150 bits used).
  logic [149:0] pending_reads[$];

  int  n_errors = 0;
  int  n_checked = 0;
  int  n_xforms = 0;
  int  n_sent = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  // out_tdata field map, lowest bit first
  int    fld_lsb [12] = '{0, 16, 32, 48, 64, 72, 84, 92, 100, 108, 116, 133};
  int    fld_wid [12] = '{16, 16, 16, 16, 8, 12, 8, 8, 8, 8, 17, 17};
  string fld_name[12] = '{"trace_a", "trace_c", "trace_g", "trace_t", "base", "position",
                          "prob_a", "prob_c", "prob_g", "prob_t", "new_left_cut",
                          "new_right_cut"};

  string alphabet = "ATCGatcgDHBVKNLMRY5678xZ-";

  task automatic report(input string what);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic logic [7:0] complement(input logic [7:0] b);
    case (b)
      "A": return "T";  "T": return "A";  "C": return "G";  "G": return "C";
      "a": return "t";  "t": return "a";  "c": return "g";  "g": return "c";
      "D": return "H";  "H": return "D";  "B": return "V";  "V": return "B";
      "K": return "N";  "N": return "K";  "L": return "M";  "M": return "L";
      "R": return "Y";  "Y": return "R";  "5": return "6";  "6": return "5";
      "7": return "7";  "8": return "8";
      default: return "-";
    endcase
  endfunction

  function automatic logic [16:0] mirrored_cut(input logic [15:0] other);
    int v;
    if (other == 0) return '0;
    v = int'(seq_len) - int'(other) + 1;
    return (v > 0) ? 17'(v) : '0;
  endfunction

  function automatic int used_points();
    return (n_points < NPTS) ? int'(n_points) : NPTS;
  endfunction

  function automatic int used_bases();
    return (n_bases < NBAS) ? int'(n_bases) : NBAS;
  endfunction

  // Reverse-complement the shadow stores in place, then run the pyro pass and mirror the cutoffs.
  function automatic void reverse_complement();
    int np, nb, tp, j1, j2;
    logic [63:0] w;
    logic [51:0] b;
    logic [11:0] pos;
    np = used_points();
    nb = used_bases();
    for (int i = 0; i < np; i++) begin
      w = trace_mem[i];
      trace_mem[i] = {w[15:0], w[31:16], w[47:32], w[63:48]};
    end
    for (int i = 0; i < np / 2; i++) begin
      w = trace_mem[i];
      trace_mem[i] = trace_mem[np-1-i];
      trace_mem[np-1-i] = w;
    end
    for (int i = 0; i < nb; i++) begin
      b = call_mem[i];
      tp = np - int'(b[19:8]) - 1;
      pos = (tp <= 0) ? 12'd0 : (tp > 4095 ? 12'd4095 : 12'(tp));
      call_mem[i] = {b[27:20], b[35:28], b[43:36], b[51:44], pos, complement(b[7:0])};
    end
    for (int i = 0; i < nb / 2; i++) begin
      b = call_mem[i];
      call_mem[i] = call_mem[nb-1-i];
      call_mem[nb-1-i] = b;
    end
    // pyro pass: walk pairs from the end, move a peak into an empty point
    if (pyro_on && nb >= 2) begin
      for (int k = nb - 1; k > 0; k--) begin
        if (call_mem[k-1][7:0] == call_mem[k][7:0]) begin
          j1 = int'(call_mem[k-1][19:8]);
          j2 = int'(call_mem[k][19:8]);
          if (trace_mem[j1] == 0) begin
            trace_mem[j1] = trace_mem[j2];
            trace_mem[j2] = '0;
          end
        end
      end
    end
    left_cut_res  = mirrored_cut(cut_right);
    right_cut_res = mirrored_cut(cut_left);
  endfunction

  // Update the shadow for one accepted word and queue any read result.
  function automatic void predict_word(input logic [2:0] cmd, input logic [127:0] d);
    logic [149:0] r;
    int idx;
    idx = int'(d[11:0]);
    r = '0;
    case (cmd)
      drt_pkg::CMD_WR_PT: trace_mem[idx] = d[75:12];
      drt_pkg::CMD_WR_BS: if (idx < NBAS) call_mem[idx] = d[127:76];
      drt_pkg::CMD_XFORM: begin
        reverse_complement();
        n_xforms++;
      end
      drt_pkg::CMD_RD_PT: begin
        r[63:0] = trace_mem[idx];
        pending_reads.push_back(r);
      end
      drt_pkg::CMD_RD_BS: begin
        if (idx < NBAS) r[115:64] = call_mem[idx];
        pending_reads.push_back(r);
      end
      drt_pkg::CMD_RD_CUT: begin
        r[132:116] = left_cut_res;
        r[149:133] = right_cut_res;
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Compare each accepted output word with the oldest expectation.
  always @(negedge clk) begin
    logic [149:0] want;
    logic [16:0] got_f, want_f;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected output word %h", out_tdata));
      end else begin
        want = pending_reads.pop_front();
        n_checked++;
        for (int f = 0; f < 12; f++) begin
          got_f  = 17'((out_tdata >> fld_lsb[f]) & ((152'd1 << fld_wid[f]) - 1));
          want_f = 17'((want >> fld_lsb[f]) & ((150'd1 << fld_wid[f]) - 1));
          if (got_f !== want_f)
            report($sformatf("read %0d field %s got %h want %h", n_checked, fld_name[f],
                             got_f, want_f));
        end
      end
    end
  end

  // Result-side ready: random stall bursts, plus one long hold-off on request.
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (k - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one word, hold it until accepted, then update the shadow.
  task automatic send_word(input logic [2:0] cmd, input logic [127:0] d);
    bit rdy;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    n_sent++;
    predict_word(cmd, d);
  endtask

  function automatic logic [127:0] point_word(input logic [11:0] idx, input logic [63:0] p);
    return {52'd0, p, idx};
  endfunction

  function automatic logic [127:0] base_word(input logic [11:0] idx, input logic [7:0] ch,
                                             input logic [11:0] pos, input logic [31:0] probs);
    return {probs, pos, ch, 64'd0, idx};
  endfunction

  function automatic logic [7:0] pick_base();
    if ($urandom_range(0, 2) == 0) return 8'($urandom);
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  // Drop valid, drain all reads, then let a full transform finish.
  task automatic settle();
    int n;
    in_tvalid <= 1'b0;
    n = 0;
    while (pending_reads.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (2 * used_points() + 8 * used_bases() + 64) @(posedge clk);
  endtask

  task automatic write_reg(input drt_pkg::reg_t r, input logic [15:0] v);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (r)
      drt_pkg::REG_POINT_COUNT: n_points = v[12:0];
      drt_pkg::REG_BASE_COUNT:  n_bases = v[10:0];
      drt_pkg::REG_SEQ_LEN:     seq_len = v;
      drt_pkg::REG_LEFT_CUT:    cut_left = v;
      drt_pkg::REG_RIGHT_CUT:   cut_right = v;
      drt_pkg::REG_PYRO_MODE:   pyro_on = v[0];
      default: ;
    endcase
  endtask

  task automatic set_all_regs(input logic [15:0] np, input logic [15:0] nb,
                              input logic [15:0] sl, input logic [15:0] lc,
                              input logic [15:0] rc, input logic [15:0] py);
    settle();
    write_reg(drt_pkg::REG_POINT_COUNT, np);
    write_reg(drt_pkg::REG_BASE_COUNT, nb);
    write_reg(drt_pkg::REG_SEQ_LEN, sl);
    write_reg(drt_pkg::REG_LEFT_CUT, lc);
    write_reg(drt_pkg::REG_RIGHT_CUT, rc);
    write_reg(drt_pkg::REG_PYRO_MODE, py);
  endtask

  // Fill the low slots of both stores; later random point reads and transforms stay inside them.
  task automatic test_fill_stores();
    bit keep;
    keep = idle_on;
    idle_on = 1'b0;
    for (int i = 0; i < FILL_PTS; i++)
      send_word(drt_pkg::CMD_WR_PT, point_word(12'(i), {$urandom, $urandom}));
    for (int i = 0; i < FILL_BS; i++)
      send_word(drt_pkg::CMD_WR_BS, base_word(12'(i), pick_base(), 12'($urandom), $urandom));
    idle_on = keep;
  endtask

  task automatic test_directed();
    // cutoffs read back as zero straight after reset
    send_word(drt_pkg::CMD_RD_CUT, '0);
    // field extremes
    send_word(drt_pkg::CMD_WR_PT, point_word(12'hFFF, 64'hFFFF_0000_FFFF_0000));
    send_word(drt_pkg::CMD_WR_PT, point_word(12'h000, 64'h0000_FFFF_0000_FFFF));
    send_word(drt_pkg::CMD_RD_PT, point_word(12'hFFF, '0));
    send_word(drt_pkg::CMD_RD_PT, point_word(12'h000, '0));
    send_word(drt_pkg::CMD_WR_BS, base_word(12'd1023, 8'hFF, 12'hFFF, 32'h7F80_807F));
    send_word(drt_pkg::CMD_RD_BS, base_word(12'd1023, '0, '0, '0));
    // base slots beyond the store: write ignored, read all zero
    send_word(drt_pkg::CMD_WR_BS, base_word(12'd1024, "A", 12'd5, '1));
    send_word(drt_pkg::CMD_RD_BS, base_word(12'd1024, '0, '0, '0));
    send_word(drt_pkg::CMD_RD_BS, base_word(12'hFFF, '0, '0, '0));
    // unknown commands do nothing
    send_word(CMD_UNUSED6, '1);
    send_word(CMD_UNUSED7, '1);
    // pyro case: empty point lands under the second of two equal bases
    set_all_regs(16'd8, 16'd3, 16'd100, 16'd0, 16'd200, 16'd1);
    for (int i = 0; i < 8; i++)
      send_word(drt_pkg::CMD_WR_PT,
                point_word(12'(i), (i == 5) ? 64'd0 : {$urandom, $urandom}));
    send_word(drt_pkg::CMD_WR_BS, base_word(12'd0, "T", 12'd1, $urandom));
    send_word(drt_pkg::CMD_WR_BS, base_word(12'd1, "T", 12'd5, $urandom));
    // position beyond point_count clamps to zero
    send_word(drt_pkg::CMD_WR_BS, base_word(12'd2, "q", 12'd4095, $urandom));
    send_word(drt_pkg::CMD_XFORM, '0);
    for (int i = 0; i < 8; i++) send_word(drt_pkg::CMD_RD_PT, point_word(12'(i), '0));
    for (int i = 0; i < 3; i++)
      send_word(drt_pkg::CMD_RD_BS, base_word(12'(i), '0, '0, '0));
    send_word(drt_pkg::CMD_RD_CUT, '0);
  endtask

  // One random command; pyro-heavy phases favor empty points and repeated bases.
  task automatic random_word(input bit pyro_bias);
    int sel, lim;
    logic [11:0] idx, bidx;
    lim = (used_points() > 0) ? used_points() - 1 : 0;
    sel = $urandom_range(0, 99);
    idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, lim));
    bidx = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(NBAS, 4095)) :
                                         12'($urandom_range(0, FILL_BS - 1));
    if (sel < 28) begin
      send_word(drt_pkg::CMD_WR_PT, point_word(idx, (pyro_bias && $urandom_range(0, 2) == 0) ?
                                                    64'd0 : {$urandom, $urandom}));
    end else if (sel < 50) begin
      send_word(drt_pkg::CMD_WR_BS,
                base_word(bidx, pyro_bias ? (($urandom_range(0, 1)) ? "A" : "T") :
                                pick_base(),
                          ($urandom_range(0, 1)) ? 12'($urandom_range(0, lim)) :
                          12'($urandom), $urandom));
    end else if (sel < 70) begin
      send_word(drt_pkg::CMD_RD_PT, point_word(12'($urandom_range(0, FILL_PTS - 1)), '0));
    end else if (sel < 88) begin
      send_word(drt_pkg::CMD_RD_BS, base_word(bidx, '0, '0, '0));
    end else if (sel < 93) begin
      send_word(drt_pkg::CMD_RD_CUT, '0);
    end else if (sel < 96) begin
      send_word(drt_pkg::CMD_XFORM, {$urandom, $urandom, $urandom, $urandom});
    end else begin
      send_word(($urandom_range(0, 1)) ? CMD_UNUSED6 : CMD_UNUSED7,
                {$urandom, $urandom, $urandom, $urandom});
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_all_regs(16'd16, 16'd8, 16'd500, 16'd20, 16'd480, 16'd0);
        1: set_all_regs(16'd32, 16'd16, 16'd300, 16'd400, 16'd1, 16'd1);
        2: set_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: set_all_regs(16'd64, 16'd32, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFE);
        4: set_all_regs(16'd63, 16'd31, 16'd4096, 16'd1, 16'hFFFF, 16'd1);
        5: set_all_regs(16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd1);
        default: set_all_regs(16'($urandom_range(2, 64)), 16'($urandom_range(2, 32)),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (int i = 0; i < 130; i++) random_word(pyro_on);
      send_word(drt_pkg::CMD_XFORM, '0);
      send_word(drt_pkg::CMD_RD_CUT, '0);
    end
  endtask

  // Stall the result side for a long stretch while reads keep coming.
  task automatic test_backpressure();
    set_all_regs(16'd24, 16'd12, 16'd77, 16'd5, 16'd9, 16'd0);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 2)
        send_word(drt_pkg::CMD_RD_PT, point_word(12'($urandom_range(0, FILL_PTS - 1)), '0));
      else
        send_word(drt_pkg::CMD_RD_BS,
                  base_word(12'($urandom_range(0, FILL_BS - 1)), '0, '0, '0));
    end
  endtask

  // Run out with no idling on either side.
  task automatic test_no_idle();
    set_all_regs(16'd40, 16'd20, 16'd1000, 16'd0, 16'd999, 16'd1);
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) random_word(1'b1);
    send_word(drt_pkg::CMD_XFORM, '0);
    for (int i = 0; i < 20; i++) send_word(drt_pkg::CMD_RD_PT, point_word(12'(i), '0));
  endtask

  initial begin
    int n;
    n_points = '0; n_bases = '0; seq_len = '0; cut_left = '0; cut_right = '0;
    pyro_on = 1'b0; left_cut_res = '0; right_cut_res = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_stores();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_no_idle();
    in_tvalid <= 1'b0;
    n = 0;
    while (pending_reads.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (2 * used_points() + 8 * used_bases() + 64) @(posedge clk);
    if (pending_reads.size() != 0) report($sformatf("%0d reads never returned",
                                                    pending_reads.size()));
    $display("Covered %0d input words, %0d checked reads and %0d transforms,",
             n_sent, n_checked, n_xforms);
    $display("including pyro passes, out-of-range slots and a long output stall.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #30ms;
    $display("Timeout with %0d reads outstanding", pending_reads.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
